// ===== design/rss_pkg.sv =====
// Package for the return stroke sequencer: constants, register indexes,
// configuration, item and result types. No dependencies.
`timescale 1ns / 1ps

package rss_pkg;

    // Sequencing constants
    localparam int MIN_STROKE_DIST = 100;
    localparam int DELAY_TICKS     = 10;
    localparam int ENC_DIV         = 4;   // power of two, position is a shift
    localparam int SETTLE_TICKS    = 8;

    localparam int ENC_SHIFT = $clog2(ENC_DIV);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] DEFAULT_ACCEL_RST = 16'd1000;
    localparam logic [15:0] DEFAULT_SPEED_RST = 16'd100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_READY_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READY_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTACT_POSITION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETURN_ACCEL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RETURN_DECEL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RETURN_VELOCITY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ACCEL    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SPEED    = 3'd7;

    // Request and outcome codes
    localparam logic REQ_ENTER = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic [1:0] OUTCOME_STAY  = 2'd0;
    localparam logic [1:0] OUTCOME_READY = 2'd1;
    localparam logic [1:0] OUTCOME_ALARM = 2'd2;

    typedef struct packed {
        logic        ready_enable;
        logic [15:0] ready_offset;
        logic [15:0] contact_position;
        logic [15:0] return_accel;
        logic [15:0] return_decel;
        logic [15:0] return_velocity;
        logic [15:0] default_accel;
        logic [15:0] fallback_speed;
    } cfg_t;

    typedef struct packed {
        logic               req_type;
        logic               alarm_active;
        logic               move_complete;
        logic signed [31:0] rotary_count;
    } item_t;

    typedef struct packed {
        logic               move_valid;
        logic [15:0]        move_target;
        logic [15:0]        move_accel;
        logic [15:0]        move_decel;
        logic [15:0]        move_velocity;
        logic [1:0]         outcome;
        logic               servo_fault;
        logic               clear_contact;
        logic signed [31:0] overshoot_value;
    } result_t;

endpackage

// ===== design/rss_channels.sv =====
// Valid/ready channel interfaces for request items and result items.
// Depends on nothing.
`timescale 1ns / 1ps

interface rss_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic               alarm_active;
    logic               move_complete;
    logic signed [31:0] rotary_count;

    modport source (output valid, output req_type, output alarm_active,
                    output move_complete, output rotary_count, input ready);
    modport sink   (input valid, input req_type, input alarm_active,
                    input move_complete, input rotary_count, output ready);
endinterface

interface rss_rsp_if;
    logic               valid;
    logic               ready;
    logic               move_valid;
    logic [15:0]        move_target;
    logic [15:0]        move_accel;
    logic [15:0]        move_decel;
    logic [15:0]        move_velocity;
    logic [1:0]         outcome;
    logic               servo_fault;
    logic               clear_contact;
    logic signed [31:0] overshoot_value;

    modport source (output valid, output move_valid, output move_target,
                    output move_accel, output move_decel, output move_velocity,
                    output outcome, output servo_fault, output clear_contact,
                    output overshoot_value, input ready);
    modport sink   (input valid, input move_valid, input move_target,
                    input move_accel, input move_decel, input move_velocity,
                    input outcome, input servo_fault, input clear_contact,
                    input overshoot_value, output ready);
endinterface

// ===== design/return_stroke_sequencer_top.sv =====
// Top level of the return stroke sequencer: input register, step logic,
// result register. Depends on rss_pkg, rss_channels, rss_cfg_regs, rss_step.
`timescale 1ns / 1ps

// Channel   Role  Beat contents
// --------  ----  ----------------------------------------------------------
// req_ch    sink  req_type, alarm_active, move_complete, rotary_count
// rsp_ch    src   move_valid/target/accel/decel/velocity, outcome,
//                 servo_fault, clear_contact, overshoot_value
// cfg_*     in    write enable, 3-bit register index, 16-bit data
//
// One beat in per cycle while results are taken, one result beat out per
// request beat; each passes the input register, then the result register.
// Reset clears the sequencer state and loads the register defaults
// (default accel 1000, default speed 100, all else 0).
// A stalled result holds in the result register while the input register
// still takes a beat; req_ch.ready drops only when both are full and the
// result is not taken.

module return_stroke_sequencer_top
    import rss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rss_req_if.sink               req_ch,
    rss_rsp_if.source             rsp_ch
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t step_res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    fire;

    rss_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance the pipe when the result register is empty or being drained
    assign advance      = !out_valid_reg || rsp_ch.ready;
    assign fire         = in_valid_reg && advance;
    assign req_ch.ready = !in_valid_reg || advance;

    // Input register: hold the beat until the step logic consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req_ch.valid && req_ch.ready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_ch.valid && req_ch.ready)
        begin
            in_item_reg.req_type      <= req_ch.req_type;
            in_item_reg.alarm_active  <= req_ch.alarm_active;
            in_item_reg.move_complete <= req_ch.move_complete;
            in_item_reg.rotary_count  <= req_ch.rotary_count;
        end
    end

    rss_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (step_res)
    );

    // Result register: load on fire, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_res_reg <= step_res;
    end

    assign rsp_ch.valid           = out_valid_reg;
    assign rsp_ch.move_valid      = out_res_reg.move_valid;
    assign rsp_ch.move_target     = out_res_reg.move_target;
    assign rsp_ch.move_accel      = out_res_reg.move_accel;
    assign rsp_ch.move_decel      = out_res_reg.move_decel;
    assign rsp_ch.move_velocity   = out_res_reg.move_velocity;
    assign rsp_ch.outcome         = out_res_reg.outcome;
    assign rsp_ch.servo_fault     = out_res_reg.servo_fault;
    assign rsp_ch.clear_contact   = out_res_reg.clear_contact;
    assign rsp_ch.overshoot_value = out_res_reg.overshoot_value;

endmodule

// ===== design/rss_cfg_regs.sv =====
// Configuration register file of the return stroke sequencer.
// Depends on rss_pkg.
`timescale 1ns / 1ps

module rss_cfg_regs
    import rss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ready_enable     <= 1'b0;
            cfg_reg.ready_offset     <= '0;
            cfg_reg.contact_position <= '0;
            cfg_reg.return_accel     <= '0;
            cfg_reg.return_decel     <= '0;
            cfg_reg.return_velocity  <= '0;
            cfg_reg.default_accel    <= DEFAULT_ACCEL_RST;
            cfg_reg.fallback_speed   <= DEFAULT_SPEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_READY_ENABLE:     cfg_reg.ready_enable     <= cfg_data[0];
                REG_READY_OFFSET:     cfg_reg.ready_offset     <= cfg_data;
                REG_CONTACT_POSITION: cfg_reg.contact_position <= cfg_data;
                REG_RETURN_ACCEL:     cfg_reg.return_accel     <= cfg_data;
                REG_RETURN_DECEL:     cfg_reg.return_decel     <= cfg_data;
                REG_RETURN_VELOCITY:  cfg_reg.return_velocity  <= cfg_data;
                REG_DEFAULT_ACCEL:    cfg_reg.default_accel    <= cfg_data;
                REG_DEFAULT_SPEED:    cfg_reg.fallback_speed   <= cfg_data;
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/rss_step.sv =====
// Sequencer state and the per-item decision logic: one item in, one result out.
// Depends on rss_pkg.
`timescale 1ns / 1ps

module rss_step
    import rss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    localparam logic signed [33:0] ERR_LIMIT = 34'(MIN_STROKE_DIST);
    localparam logic signed [17:0] STROKE_18 = 18'(MIN_STROKE_DIST);

    logic               active_reg, active_next;
    logic [15:0]        ready_target_reg, ready_target_next;
    logic [3:0]         settle_count_reg, settle_count_next;
    logic [7:0]         delay_count_reg, delay_count_next;
    logic signed [31:0] overshoot_reg, overshoot_next;

    logic signed [32:0] biased;
    logic signed [32:0] pos_shift;
    logic signed [33:0] pos;
    logic [15:0]        enter_diff;
    logic               enter_ok;
    logic               profile_ok;
    logic signed [17:0] retarget_lim;
    logic [15:0]        retarget;
    logic signed [33:0] err;
    logic signed [34:0] ov_diff;
    logic signed [31:0] ov_sat;
    logic               err_ok;

    always_comb
    begin
        // Position truncated toward zero: bias negatives before the shift
        biased    = 33'(item.rotary_count)
                  + (item.rotary_count[31] ? 33'(ENC_DIV - 1) : 33'sd0);
        pos_shift = biased >>> ENC_SHIFT;
        pos       = 34'(pos_shift);

        enter_diff = cfg.contact_position - cfg.ready_offset;
        enter_ok   = cfg.ready_enable
                  && (cfg.ready_offset >= 16'(MIN_STROKE_DIST))
                  && (cfg.ready_offset <= cfg.contact_position)
                  && ($signed({18'd0, enter_diff}) < pos);
        profile_ok = (cfg.return_accel != '0) && (cfg.return_decel != '0)
                  && (cfg.return_velocity != '0);

        retarget_lim = $signed({2'b00, cfg.contact_position}) - STROKE_18;
        retarget     = ((ready_target_reg != '0)
                       && ($signed({2'b00, ready_target_reg}) < retarget_lim))
                     ? ready_target_reg : '0;

        err     = pos - $signed({18'd0, ready_target_reg});
        err_ok  = (err < ERR_LIMIT) && (err > -ERR_LIMIT);
        ov_diff = 35'(overshoot_reg) - 35'(err);
        if (ov_diff[34:31] == 4'b0000 || ov_diff[34:31] == 4'b1111)
            ov_sat = ov_diff[31:0];
        else if (ov_diff[34])
            ov_sat = 32'sh8000_0000;
        else
            ov_sat = 32'sh7fff_ffff;

        active_next       = active_reg;
        ready_target_next = ready_target_reg;
        settle_count_next = settle_count_reg;
        delay_count_next  = delay_count_reg;
        overshoot_next    = overshoot_reg;
        res               = '0;

        if (item.req_type == REQ_ENTER)
        begin
            ready_target_next = enter_ok ? enter_diff : '0;
            res.move_valid    = 1'b1;
            if (profile_ok)
            begin
                res.move_target   = ready_target_next;
                res.move_accel    = cfg.return_accel;
                res.move_decel    = cfg.return_decel;
                res.move_velocity = cfg.return_velocity;
            end
            else
            begin
                res.move_accel    = cfg.default_accel;
                res.move_decel    = cfg.default_accel;
                res.move_velocity = cfg.fallback_speed;
            end
            res.clear_contact = 1'b1;
            delay_count_next  = 8'(DELAY_TICKS);
            settle_count_next = 4'(SETTLE_TICKS);
            active_next       = 1'b1;
        end
        else if (active_reg)
        begin
            if (item.alarm_active)
            begin
                res.outcome = OUTCOME_ALARM;
                active_next = 1'b0;
            end
            else if (settle_count_reg != '0)
            begin
                settle_count_next = settle_count_reg - 4'd1;
                if (item.move_complete)
                begin
                    // Stale move done: re-send the move
                    res.move_valid = 1'b1;
                    if (profile_ok)
                    begin
                        res.move_target   = retarget;
                        res.move_accel    = cfg.return_accel;
                        res.move_decel    = cfg.return_decel;
                        res.move_velocity = cfg.return_velocity;
                    end
                    else
                    begin
                        res.move_accel    = cfg.default_accel;
                        res.move_decel    = cfg.default_accel;
                        res.move_velocity = cfg.fallback_speed;
                    end
                end
            end
            else if (item.move_complete)
            begin
                if (delay_count_reg != '0)
                    delay_count_next = delay_count_reg - 8'd1;
                else
                begin
                    if (err_ok)
                    begin
                        overshoot_next = ov_sat;
                        res.outcome    = OUTCOME_READY;
                    end
                    else
                    begin
                        res.outcome     = OUTCOME_ALARM;
                        res.servo_fault = 1'b1;
                    end
                    active_next = 1'b0;
                end
            end
        end

        res.overshoot_value = overshoot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            ready_target_reg <= '0;
            settle_count_reg <= '0;
            delay_count_reg  <= '0;
            overshoot_reg    <= '0;
        end
        else if (fire)
        begin
            active_reg       <= active_next;
            ready_target_reg <= ready_target_next;
            settle_count_reg <= settle_count_next;
            delay_count_reg  <= delay_count_next;
            overshoot_reg    <= overshoot_next;
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for return_stroke_sequencer_top: valid/ready request and
// result channels, the register write port, and an in-line sequencer predictor.
// Depends on rss_pkg, rss_channels and the design under design/.
`timescale 1ns / 1ps

module tb_top;
    import rss_pkg::*;

    // Generous ceiling for a clean run.
    localparam longint RUN_LIMIT_NS = 64'd5_000_000;
    // Length of a deliberate receiver hold-off, in cycles.
    localparam int LONG_STALL = 64;

    typedef enum int {STROKE_GOOD, STROKE_FAR, STROKE_ALARM, STROKE_CUT} stroke_kind_t;
    typedef enum int {
        SET_TYPICAL, SET_MIN_OFFSET, SET_DEFAULT_PROFILE,
        SET_ZERO_GAP, SET_DISABLED, SET_WILD
    } setting_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rss_req_if req_ch();
    rss_rsp_if rsp_ch();

    return_stroke_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_ch    (req_ch.sink),
        .rsp_ch    (rsp_ch.source)
    );

    // ------------------------------------------------------------------
    // Predictor state: register copy and sequencer state, reset values
    // ------------------------------------------------------------------
    cfg_t cfg_shadow = '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                         DEFAULT_ACCEL_RST, DEFAULT_SPEED_RST};

    bit          seq_active    = 1'b0;
    logic [15:0] seq_ready_pos = 16'd0;
    logic [3:0]  settle_left   = 4'd0;
    logic [7:0]  delay_left    = 8'd0;
    int          overshoot_acc = 0;

    item_t   stroke_requests[$];     // beats waiting for the driver
    result_t predicted_replies[$];   // results owed by the block, oldest first

    // Run bookkeeping
    int n_queued   = 0;
    int n_items    = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_enters   = 0;
    int n_resends  = 0;
    int n_ready    = 0;
    int n_alarms   = 0;
    int n_faults   = 0;
    int n_settings = 1;

    // Percent chance per cycle of starting an idle burst, on either side.
    // Zero means a stretch with no idling at all (and no long hold-off).
    int gap_pct = 0;

    bit req_taken   = 1'b0;
    int gap_left    = 0;
    int hold_left   = 0;
    int stalls_done = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Ready position chosen at enter: contact minus offset when the offset
    // is enabled, sane, and the part is still beyond that point; else home.
    function automatic logic [15:0] ready_point(longint pos);
        logic [15:0] gap_to_contact;
        gap_to_contact = cfg_shadow.contact_position - cfg_shadow.ready_offset;
        if (cfg_shadow.ready_enable
                && cfg_shadow.ready_offset >= MIN_STROKE_DIST
                && cfg_shadow.ready_offset <= cfg_shadow.contact_position
                && longint'(gap_to_contact) < pos)
            return gap_to_contact;
        return 16'd0;
    endfunction

    function automatic result_t with_move(result_t r, logic [15:0] tgt, logic [15:0] acc,
                                          logic [15:0] dec, logic [15:0] vel);
        r.move_valid    = 1'b1;
        r.move_target   = tgt;
        r.move_accel    = acc;
        r.move_decel    = dec;
        r.move_velocity = vel;
        return r;
    endfunction

    // Apply one request beat to the predicted sequencer; return its result.
    function automatic result_t advance_sequencer(item_t it);
        result_t r;
        longint  pos;
        longint  lim;
        longint  err;
        longint  acc;
        bit      profile_ok;
        r = '0;
        // Encoder count to position, truncating toward zero.
        pos = longint'($signed(it.rotary_count)) / ENC_DIV;
        profile_ok = cfg_shadow.return_accel != 0 && cfg_shadow.return_decel != 0
                     && cfg_shadow.return_velocity != 0;
        if (it.req_type == REQ_ENTER)
        begin
            n_enters++;
            seq_ready_pos = ready_point(pos);
            if (profile_ok)
                r = with_move(r, seq_ready_pos, cfg_shadow.return_accel,
                              cfg_shadow.return_decel, cfg_shadow.return_velocity);
            else
                r = with_move(r, 16'd0, cfg_shadow.default_accel,
                              cfg_shadow.default_accel, cfg_shadow.fallback_speed);
            r.clear_contact = 1'b1;
            delay_left  = 8'(DELAY_TICKS);
            settle_left = 4'(SETTLE_TICKS);
            seq_active  = 1'b1;
        end
        else if (seq_active)
        begin
            if (it.alarm_active)
            begin
                r.outcome  = OUTCOME_ALARM;
                seq_active = 1'b0;
                n_alarms++;
            end
            else if (settle_left != 0)
            begin
                settle_left--;
                // A stale move done inside the settle window re-sends the move.
                if (it.move_complete)
                begin
                    n_resends++;
                    lim = longint'(cfg_shadow.contact_position) - MIN_STROKE_DIST;
                    if (profile_ok)
                        r = with_move(r,
                            (seq_ready_pos != 0 && longint'(seq_ready_pos) < lim)
                                ? seq_ready_pos : 16'd0,
                            cfg_shadow.return_accel, cfg_shadow.return_decel,
                            cfg_shadow.return_velocity);
                    else
                        r = with_move(r, 16'd0, cfg_shadow.default_accel,
                                      cfg_shadow.default_accel, cfg_shadow.fallback_speed);
                end
            end
            else if (it.move_complete)
            begin
                if (delay_left != 0)
                begin
                    delay_left--;
                end
                else
                begin
                    err = pos - longint'(seq_ready_pos);
                    if (err < MIN_STROKE_DIST && err > -MIN_STROKE_DIST)
                    begin
                        // Fold the error into the accumulator, clamped to int32.
                        acc = longint'(overshoot_acc) - err;
                        if (acc > 64'sd2147483647)
                            acc = 64'sd2147483647;
                        if (acc < -64'sd2147483648)
                            acc = -64'sd2147483648;
                        overshoot_acc = int'(acc);
                        r.outcome = OUTCOME_READY;
                        n_ready++;
                    end
                    else
                    begin
                        r.outcome     = OUTCOME_ALARM;
                        r.servo_fault = 1'b1;
                        n_faults++;
                    end
                    seq_active = 1'b0;
                end
            end
        end
        r.overshoot_value = overshoot_acc;
        return r;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Encoder count that lands exactly on position x, with random fraction.
    function automatic logic [31:0] count_for(longint x);
        longint frac;
        longint v;
        frac = longint'($urandom_range(0, 3));
        if (x > 0 || (x == 0 && $urandom_range(0, 1) == 0))
            v = x * ENC_DIV + frac;
        else
            v = x * ENC_DIV - frac;
        return v[31:0];
    endfunction

    task automatic queue_item(logic req, logic alarm, logic done, logic [31:0] rc,
                              bit counted);
        item_t it;
        it.req_type      = req;
        it.alarm_active  = alarm;
        it.move_complete = done;
        it.rotary_count  = rc;
        stroke_requests.push_back(it);
        if (counted)
            n_queued++;
    endtask

    // One return stroke: enter, settle window, delay ticks, position check.
    // Alarm and cut strokes stop at a random tick; a cut stroke leaves the
    // sequencer active so the next enter restarts it.
    task automatic queue_stroke(stroke_kind_t kind);
        longint      diff;
        longint      pos;
        longint      e;
        logic [31:0] rc;
        logic [15:0] rt;
        int          cut;
        int          ticks;
        int          settle;
        int          done_needed;
        int          mode;
        diff = longint'(cfg_shadow.contact_position) - longint'(cfg_shadow.ready_offset);
        mode = $urandom_range(0, 9);
        if (mode <= 5)
            pos = diff + longint'($urandom_range(1, 3000));
        else if (mode == 6)
            pos = diff;                       // equal is not beyond the ready point
        else if (mode == 7)
            pos = diff - longint'($urandom_range(1, 3000));
        else
            pos = longint'($urandom_range(0, 65535));
        rc  = (mode == 8) ? $urandom : count_for(pos);
        pos = longint'($signed(rc)) / ENC_DIV;
        rt  = ready_point(pos);
        queue_item(REQ_ENTER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rc, 1'b1);

        cut = (kind == STROKE_ALARM || kind == STROKE_CUT)
              ? int'($urandom_range(0, SETTLE_TICKS + DELAY_TICKS)) : -1;
        ticks       = 0;
        settle      = SETTLE_TICKS;
        done_needed = DELAY_TICKS;
        while (settle > 0 || done_needed > 0)
        begin
            if (ticks == cut)
            begin
                if (kind == STROKE_ALARM)
                    queue_item(REQ_TICK, 1'b1, 1'($urandom_range(0, 1)), $urandom, 1'b1);
                return;
            end
            if (settle > 0)
            begin
                queue_item(REQ_TICK, 1'b0, 1'($urandom_range(0, 1)), $urandom, 1'b1);
                settle--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                queue_item(REQ_TICK, 1'b0, 1'b0, $urandom, 1'b1);
            end
            else
            begin
                queue_item(REQ_TICK, 1'b0, 1'b1, $urandom, 1'b1);
                done_needed--;
            end
            ticks++;
        end

        // Position check: inside the window (edges included) or outside it.
        if (kind == STROKE_GOOD)
        begin
            if ($urandom_range(0, 9) == 0)
                e = ($urandom_range(0, 1) != 0) ? 99 : -99;
            else
                e = longint'($urandom_range(0, 198)) - 99;
            rc = count_for(longint'(rt) + e);
        end
        else
        begin
            e = ($urandom_range(0, 1) != 0) ? 1 : -1;
            case ($urandom_range(0, 2))
                0: rc = count_for(longint'(rt) + e * MIN_STROKE_DIST);
                1: rc = count_for(longint'(rt) + e * longint'(100 + $urandom_range(0, 60000)));
                default: rc = $urandom;
            endcase
        end
        queue_item(REQ_TICK, 1'b0, 1'b1, rc, 1'b1);
    endtask

    task automatic run_strokes(int budget);
        int goal;
        int sel;
        goal = n_queued + budget;
        while (n_queued < goal)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 62)
                queue_stroke(STROKE_GOOD);
            else if (sel < 74)
                queue_stroke(STROKE_FAR);
            else if (sel < 84)
                queue_stroke(STROKE_ALARM);
            else if (sel < 92)
                queue_stroke(STROKE_CUT);
            else
                // Noise: random beats, enters and ticks alike, outside the budget.
                repeat ($urandom_range(1, 4))
                    queue_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), $urandom, 1'b0);
        end
    endtask

    // Hold until every queued beat went in and every result came back,
    // then let the two pipeline stages go quiet.
    task automatic wait_drained();
        while (stroke_requests.size() != 0 || req_ch.valid
               || predicted_replies.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all eight registers; only called while the block is idle.
    task automatic apply_config(cfg_t c);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = REG_READY_ENABLE;
        cfg_data  = {15'd0, c.ready_enable};
        @(negedge clk);
        cfg_index = REG_READY_OFFSET;
        cfg_data  = c.ready_offset;
        @(negedge clk);
        cfg_index = REG_CONTACT_POSITION;
        cfg_data  = c.contact_position;
        @(negedge clk);
        cfg_index = REG_RETURN_ACCEL;
        cfg_data  = c.return_accel;
        @(negedge clk);
        cfg_index = REG_RETURN_DECEL;
        cfg_data  = c.return_decel;
        @(negedge clk);
        cfg_index = REG_RETURN_VELOCITY;
        cfg_data  = c.return_velocity;
        @(negedge clk);
        cfg_index = REG_DEFAULT_ACCEL;
        cfg_data  = c.default_accel;
        @(negedge clk);
        cfg_index = REG_DEFAULT_SPEED;
        cfg_data  = c.fallback_speed;
        @(negedge clk);
        cfg_we     = 1'b0;
        cfg_shadow = c;
        n_settings++;
    endtask

    function automatic cfg_t pick_config(setting_t setting);
        cfg_t c;
        c.ready_enable     = 1'b1;
        c.ready_offset     = 16'($urandom_range(100, 3000));
        c.contact_position = 16'($urandom_range(5000, 65535));
        c.return_accel     = 16'($urandom_range(1, 65535));
        c.return_decel     = 16'($urandom_range(1, 65535));
        c.return_velocity  = 16'($urandom_range(1, 65535));
        c.default_accel    = 16'($urandom_range(0, 65535));
        c.fallback_speed   = 16'($urandom_range(0, 65535));
        case (setting)
            SET_MIN_OFFSET:
            begin
                // Offset right at the minimum: re-sends fall back to home.
                c.ready_offset     = 16'(MIN_STROKE_DIST);
                c.contact_position = 16'($urandom_range(100, 65535));
            end
            SET_DEFAULT_PROFILE:
            begin
                // Any single zero in the return profile selects the default one.
                case ($urandom_range(0, 2))
                    0: c.return_accel = 16'd0;
                    1: c.return_decel = 16'd0;
                    default: c.return_velocity = 16'd0;
                endcase
            end
            SET_ZERO_GAP:
            begin
                c.ready_offset     = 16'hFFFF;
                c.contact_position = 16'hFFFF;
                c.default_accel    = 16'hFFFF;
                c.fallback_speed   = 16'hFFFF;
            end
            SET_DISABLED:
            begin
                c.ready_enable    = 1'b0;
                c.return_accel    = 16'hFFFF;
                c.return_decel    = 16'hFFFF;
                c.return_velocity = 16'hFFFF;
                c.default_accel   = 16'd0;
                c.fallback_speed  = 16'd0;
            end
            SET_WILD:
            begin
                c.ready_enable     = 1'($urandom_range(0, 1));
                c.ready_offset     = 16'($urandom_range(0, 65535));
                c.contact_position = 16'($urandom_range(0, 65535));
                c.return_accel     = 16'($urandom_range(0, 65535));
            end
            default: ;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Request driver: change at the falling edge, hold a beat until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : request_driver
        item_t nxt;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (req_ch.valid && !req_taken)
        begin
            // Hold the offered beat until the block takes it.
        end
        else if (gap_left > 0)
        begin
            gap_left     <= gap_left - 1;
            req_ch.valid <= 1'b0;
        end
        else if (stroke_requests.size() != 0 && gap_pct != 0
                 && $urandom_range(0, 99) < gap_pct)
        begin
            // Start an idle burst with valid low.
            gap_left     <= $urandom_range(0, 3);
            req_ch.valid <= 1'b0;
        end
        else if (stroke_requests.size() != 0)
        begin
            nxt = stroke_requests.pop_front();
            req_ch.valid         <= 1'b1;
            req_ch.req_type      <= nxt.req_type;
            req_ch.alarm_active  <= nxt.alarm_active;
            req_ch.move_complete <= nxt.move_complete;
            req_ch.rotary_count  <= nxt.rotary_count;
        end
        else
        begin
            req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random short stalls plus two long hold-offs that
    // back the block up until it drops its request ready
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : result_receiver
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (gap_pct != 0 && stalls_done < 2
                 && n_results >= 300 + stalls_done * 800)
        begin
            hold_left    <= LONG_STALL - 1;
            stalls_done  <= stalls_done + 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            hold_left    <= $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge check a taken result against the oldest
    // prediction, and predict the result of a taken request beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : beat_monitor
        item_t   it;
        result_t got;
        result_t want;
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_results++;
            got.move_valid      = rsp_ch.move_valid;
            got.move_target     = rsp_ch.move_target;
            got.move_accel      = rsp_ch.move_accel;
            got.move_decel      = rsp_ch.move_decel;
            got.move_velocity   = rsp_ch.move_velocity;
            got.outcome         = rsp_ch.outcome;
            got.servo_fault     = rsp_ch.servo_fault;
            got.clear_contact   = rsp_ch.clear_contact;
            got.overshoot_value = rsp_ch.overshoot_value;
            if (predicted_replies.size() == 0)
            begin
                n_errors++;
                $display("%0t: result beat with nothing expected, actual %h", $time, got);
            end
            else
            begin
                want = predicted_replies.pop_front();
                check_field("move_valid", 32'(want.move_valid), 32'(got.move_valid));
                check_field("move_target", 32'(want.move_target), 32'(got.move_target));
                check_field("move_accel", 32'(want.move_accel), 32'(got.move_accel));
                check_field("move_decel", 32'(want.move_decel), 32'(got.move_decel));
                check_field("move_velocity", 32'(want.move_velocity),
                            32'(got.move_velocity));
                check_field("outcome", 32'(want.outcome), 32'(got.outcome));
                check_field("servo_fault", 32'(want.servo_fault), 32'(got.servo_fault));
                check_field("clear_contact", 32'(want.clear_contact),
                            32'(got.clear_contact));
                check_field("overshoot_value", want.overshoot_value, got.overshoot_value);
            end
        end
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            n_items++;
            it.req_type      = req_ch.req_type;
            it.alarm_active  = req_ch.alarm_active;
            it.move_complete = req_ch.move_complete;
            it.rotary_count  = req_ch.rotary_count;
            predicted_replies.push_back(advance_sequencer(it));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        // Drive every input to a known value from time zero.
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_READY_ENABLE;
        cfg_data             = '0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_ENTER;
        req_ch.alarm_active  = 1'b0;
        req_ch.move_complete = 1'b0;
        req_ch.rotary_count  = '0;
        rsp_ch.ready         = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset settings (default profile): idle ticks at the
        // count extremes, enter, re-send, alarm, tick after alarm, and an
        // enter that restarts a running stroke.
        gap_pct = 20;
        queue_item(REQ_TICK, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1);
        queue_item(REQ_TICK, 1'b0, 1'b1, 32'h8000_0000, 1'b1);
        queue_item(REQ_ENTER, 1'b0, 1'b0, 32'h8000_0000, 1'b1);
        queue_item(REQ_TICK, 1'b0, 1'b1, 32'h0000_0000, 1'b1);
        queue_item(REQ_TICK, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1);
        queue_item(REQ_TICK, 1'b1, 1'b0, 32'h1234_5678, 1'b1);
        queue_item(REQ_TICK, 1'b0, 1'b1, 32'h0000_0010, 1'b1);
        queue_item(REQ_ENTER, 1'b1, 1'b1, 32'h0000_0000, 1'b1);
        queue_item(REQ_ENTER, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b1);
        queue_item(REQ_TICK, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1);
        wait_drained();

        // Directed, extreme settings: full-scale profile, zero defaults,
        // offset at the minimum so the re-send targets home.
        apply_config('{1'b1, 16'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'd0, 16'd0});
        queue_item(REQ_ENTER, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b1);
        queue_item(REQ_TICK, 1'b0, 1'b1, 32'h8000_0000, 1'b1);
        queue_stroke(STROKE_GOOD);
        wait_drained();

        // Random strokes across several register settings.
        gap_pct = 25;
        apply_config(pick_config(SET_TYPICAL));
        run_strokes(270);
        wait_drained();

        gap_pct = 0;
        apply_config(pick_config(SET_MIN_OFFSET));
        run_strokes(270);
        wait_drained();

        // Pause the sender halfway until every result is back.
        gap_pct = 40;
        apply_config(pick_config(SET_DEFAULT_PROFILE));
        run_strokes(135);
        wait_drained();
        run_strokes(135);
        wait_drained();

        gap_pct = 15;
        apply_config(pick_config(SET_ZERO_GAP));
        run_strokes(270);
        wait_drained();

        gap_pct = 30;
        apply_config(pick_config(SET_DISABLED));
        run_strokes(270);
        wait_drained();

        gap_pct = 20;
        apply_config(pick_config(SET_WILD));
        run_strokes(270);
        wait_drained();

        // Closing stretch at full rate, no idling on either side.
        gap_pct = 0;
        apply_config(pick_config(SET_TYPICAL));
        run_strokes(270);
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Covered %0d request beats, %0d register settings, %0d enters, %0d re-sends.",
                 n_items, n_settings, n_enters, n_resends);
        $display("%0d results checked: %0d ready, %0d alarms, %0d faults, %0d long stalls.",
                 n_results, n_ready, n_alarms, n_faults, stalls_done);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Stop a hung run.
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results still owed", predicted_replies.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
